FILE: rtl/depth_waypoint_controller_top_defines.svh
// assertion macros shared by the checker
`ifndef DEPTH_WAYPOINT_CONTROLLER_TOP_DEFINES_SVH
`define DEPTH_WAYPOINT_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DWC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dwc_pkg.sv
package dwc_pkg;

    localparam int MAX_POINTS   = 4;
    localparam int NUM_WP_REGS  = 4;
    localparam int WP_W         = 15;
    localparam int IDX_W        = 2;
    localparam int CNT_W        = 3;
    localparam int DWELL_W      = 16;
    localparam int GAIN_W       = 16;
    localparam int MARGIN_W     = 12;
    localparam int DEPTH_W      = 16;
    localparam int TIME_W       = 32;
    localparam int EFFORT_W     = 16;
    localparam int DIST_W       = 16;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 56;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CNT_W-1:0]          RESET_COUNT  = CNT_W'(1);
    localparam logic [GAIN_W-1:0]         RESET_GAIN   = GAIN_W'(256);
    localparam logic [MARGIN_W-1:0]       RESET_MARGIN = MARGIN_W'(100);
    localparam logic signed [EFFORT_W-1:0] SURFACE_EFFORT = -EFFORT_W'(80);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAYPOINT_A     = 3'd0,
        REG_WAYPOINT_B     = 3'd1,
        REG_WAYPOINT_C     = 3'd2,
        REG_WAYPOINT_D     = 3'd3,
        REG_WAYPOINT_COUNT = 3'd4,
        REG_DWELL_TIME     = 3'd5,
        REG_GAIN           = 3'd6,
        REG_ARRIVAL_MARGIN = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_WP_REGS-1:0][WP_W-1:0] waypoint;
        logic [CNT_W-1:0]                 count;
        logic [DWELL_W-1:0]               dwell_time;
        logic [GAIN_W-1:0]                gain;
        logic [MARGIN_W-1:0]              margin;
    } cfg_t;

    // clamp the programmed count to 1..MAX_POINTS
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (r == '0) r = CNT_W'(1);
        if (r > CNT_W'(MAX_POINTS)) r = CNT_W'(MAX_POINTS);
        return r;
    endfunction

endpackage

FILE: rtl/depth_waypoint_controller_top.sv
// an accepted input reaches m_tvalid through the input register, then the result register
// throughput: one transaction per cycle while m_tready does not stall the result register,
// set by the combinational pass through the step logic
// a stalled result holds in the result register while one more input waits in the input register
// reset: synchronous on aresetn low; clears valid flags and controller state, restores
// register defaults (waypoint_count 1, gain 256, arrival_margin 100, others 0)
module depth_waypoint_controller_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dwc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dwc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tuser,  // kind: 0 dive step, 1 surface step
    input  logic [dwc_pkg::S_TDATA_W-1:0]      s_tdata,  // measured_depth[15:0], time_stamp[47:16]
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // effort[15:0], desired_depth[30:16], distance[46:31], waypoint_index[48:47],
    // dwelling[49], reached_depth[50], surfaced[51], zero fill[55:52]
    output logic [dwc_pkg::M_TDATA_W-1:0]      m_tdata
);
    import dwc_pkg::*;

    // current register file contents, held for the step logic
    cfg_t cfg;

    // register file, always ready, one write transaction per cycle
    dwc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register, waypoint sequencer, p-control effort and result register
    dwc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/dwc_cfg_regs.sv
module dwc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dwc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dwc_pkg::cfg_t                  cfg
);
    import dwc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WAYPOINT_A:     cfg_next.waypoint[0] = cfg_data[WP_W-1:0];
                REG_WAYPOINT_B:     cfg_next.waypoint[1] = cfg_data[WP_W-1:0];
                REG_WAYPOINT_C:     cfg_next.waypoint[2] = cfg_data[WP_W-1:0];
                REG_WAYPOINT_D:     cfg_next.waypoint[3] = cfg_data[WP_W-1:0];
                REG_WAYPOINT_COUNT: cfg_next.count       = cfg_data[CNT_W-1:0];
                REG_DWELL_TIME:     cfg_next.dwell_time  = cfg_data[DWELL_W-1:0];
                REG_GAIN:           cfg_next.gain        = cfg_data[GAIN_W-1:0];
                REG_ARRIVAL_MARGIN: cfg_next.margin      = cfg_data[MARGIN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.waypoint   <= '0;
            cfg_reg.count      <= RESET_COUNT;
            cfg_reg.dwell_time <= '0;
            cfg_reg.gain       <= RESET_GAIN;
            cfg_reg.margin     <= RESET_MARGIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/dwc_effort.sv
module dwc_effort (
    input  logic [dwc_pkg::WP_W-1:0]            desired,
    input  logic signed [dwc_pkg::DEPTH_W-1:0]  measured,
    input  logic [dwc_pkg::GAIN_W-1:0]          gain,
    output logic signed [dwc_pkg::EFFORT_W-1:0] effort
);
    import dwc_pkg::*;

    localparam int ERR_W  = DEPTH_W + 1;
    localparam int PROD_W = ERR_W + GAIN_W + 1;

    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  gain_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] quot;

    // 2 * gain * err / 256 with floor is an arithmetic shift by 7
    always_comb begin
        err    = $signed({{(ERR_W-WP_W){1'b0}}, desired}) - $signed({measured[DEPTH_W-1], measured});
        gain_s = $signed({1'b0, gain});
        prod   = PROD_W'(err) * PROD_W'(gain_s);
        quot   = prod >>> 7;
        if (quot > PROD_W'(32767)) begin
            effort = EFFORT_W'(32767);
        end else if (quot < -PROD_W'(32768)) begin
            effort = $signed({1'b1, {(EFFORT_W-1){1'b0}}});
        end else begin
            effort = quot[EFFORT_W-1:0];
        end
    end

endmodule

FILE: rtl/dwc_core.sv
module dwc_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dwc_pkg::cfg_t                     cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,
    input  logic [dwc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dwc_pkg::M_TDATA_W-1:0]     m_tdata
);
    import dwc_pkg::*;

    // input register
    logic                      in_valid_reg;
    logic                      in_kind_reg;
    logic signed [DEPTH_W-1:0] in_depth_reg;
    logic [TIME_W-1:0]         in_time_reg;

    // controller state
    logic [IDX_W-1:0]           point_index_reg, point_index_next;
    logic                       dwell_flag_reg, dwell_flag_next;
    logic [TIME_W-1:0]          dwell_start_reg, dwell_start_next;
    logic                       depth_done_reg, depth_done_next;
    logic                       surface_done_reg, surface_done_next;
    logic signed [EFFORT_W-1:0] held_effort_reg, held_effort_next;
    logic [DIST_W-1:0]          held_distance_reg, held_distance_next;

    // result register
    logic                       out_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;
    logic [M_TDATA_W-1:0]       out_data_next;

    logic                       advance;
    logic                       in_take;
    logic [WP_W-1:0]            target;
    logic signed [DEPTH_W:0]    diff;
    logic [DIST_W-1:0]          abs_dist;
    logic                       near;
    logic [TIME_W-1:0]          start_eff;
    logic [TIME_W:0]            dwell_end;
    logic                       running;
    logic [IDX_W-1:0]           idx_inc;
    logic [CNT_W-1:0]           cnt;
    logic [WP_W-1:0]            new_target;
    logic signed [EFFORT_W-1:0] p_effort;
    logic [WP_W-1:0]            desired;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // waypoint sequencing
    always_comb begin
        point_index_next   = point_index_reg;
        dwell_flag_next    = dwell_flag_reg;
        dwell_start_next   = dwell_start_reg;
        depth_done_next    = depth_done_reg;
        held_distance_next = held_distance_reg;

        target    = cfg.waypoint[point_index_reg];
        diff      = $signed({2'b00, target}) - $signed({in_depth_reg[DEPTH_W-1], in_depth_reg});
        abs_dist  = diff[DEPTH_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
        near      = ({{(DIST_W-MARGIN_W){1'b0}}, cfg.margin} > abs_dist) || dwell_flag_reg;
        start_eff = (dwell_start_reg == '0) ? in_time_reg : dwell_start_reg;
        dwell_end = {1'b0, start_eff} + {{(TIME_W+1-DWELL_W){1'b0}}, cfg.dwell_time};
        running   = {1'b0, in_time_reg} < dwell_end;
        idx_inc   = point_index_reg + IDX_W'(1);
        cnt       = active_count(cfg.count);

        if (!in_kind_reg && !depth_done_reg) begin
            held_distance_next = abs_dist;
            if (near) begin
                if (running) begin
                    dwell_flag_next  = 1'b1;
                    dwell_start_next = start_eff;
                end else begin
                    dwell_flag_next  = 1'b0;
                    dwell_start_next = '0;
                    point_index_next = idx_inc;
                    if (idx_inc == '0 || {1'b0, idx_inc} >= cnt) begin
                        depth_done_next  = 1'b1;
                        point_index_next = '0;
                    end
                end
            end
        end
    end

    assign new_target = cfg.waypoint[point_index_next];

    dwc_effort u_effort (
        .desired  (new_target),
        .measured (in_depth_reg),
        .gain     (cfg.gain),
        .effort   (p_effort)
    );

    // effort, surfacing and result packing
    always_comb begin
        held_effort_next  = held_effort_reg;
        surface_done_next = surface_done_reg;
        desired           = new_target;
        if (!in_kind_reg) begin
            if (!depth_done_reg) begin
                held_effort_next = depth_done_next ? '0 : p_effort;
            end
        end else begin
            desired = '0;
            if ($signed(in_depth_reg) < $signed({{(DEPTH_W-MARGIN_W){1'b0}}, cfg.margin})
                    || dwell_flag_reg) begin
                surface_done_next = 1'b1;
                held_effort_next  = '0;
            end else begin
                held_effort_next  = SURFACE_EFFORT;
            end
        end
        out_data_next = {4'b0000, surface_done_next, depth_done_next, dwell_flag_next,
                         point_index_next, held_distance_next, desired, held_effort_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            point_index_reg   <= '0;
            dwell_flag_reg    <= 1'b0;
            dwell_start_reg   <= '0;
            depth_done_reg    <= 1'b0;
            surface_done_reg  <= 1'b0;
            held_effort_reg   <= '0;
            held_distance_reg <= '0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg     <= 1'b1;
                point_index_reg   <= point_index_next;
                dwell_flag_reg    <= dwell_flag_next;
                dwell_start_reg   <= dwell_start_next;
                depth_done_reg    <= depth_done_next;
                surface_done_reg  <= surface_done_next;
                held_effort_reg   <= held_effort_next;
                held_distance_reg <= held_distance_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg  <= s_tuser;
            in_depth_reg <= s_tdata[DEPTH_W-1:0];
            in_time_reg  <= s_tdata[DEPTH_W+TIME_W-1:DEPTH_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: rtl/dwc_checker.sv
`include "depth_waypoint_controller_top_defines.svh"

module dwc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dwc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dwc_pkg::*;

    // a stalled result transaction keeps its payload
    `DWC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // finishing the dive points back to the first waypoint
    `DWC_ASSERT_SAME(a_done_idx, m_tvalid && m_tdata[50], m_tdata[48:47] == 2'b00, "reached_depth with nonzero index")

    // the dwell is cleared when the dive completes
    `DWC_ASSERT_SAME(a_dwell_done, m_tvalid && m_tdata[49], !m_tdata[50], "dwelling after reached_depth")

endmodule

bind depth_waypoint_controller_top dwc_checker u_dwc_checker (.*);

FILE: dv/waypoint_step_checker.sv
module waypoint_step_checker
    import dwc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   s_tuser,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int                     fail_count,
    output int                     pending
);

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]         pad;
        logic               surfaced;
        logic               reached;
        logic               dwelling;
        logic [1:0]         index;
        logic [15:0]        distance;
        logic [14:0]        desired;
        logic signed [15:0] effort;
    } step_result_t;

    // programmed registers
    logic [14:0] wp_tab [4];
    logic [2:0]  wp_count;
    logic [15:0] hold_len;
    logic [15:0] kp;
    logic [11:0] margin;

    // controller state
    logic [1:0]         leg;
    logic               dwell_on;
    logic [31:0]        dwell_t0;
    logic               dive_done;
    logic               surf_done;
    logic signed [15:0] held_eff;
    logic [15:0]        held_dist;

    step_result_t expected_steps[$];

    // 2 * gain * error in Q8.8, floored, clamped to 16 bits
    function automatic logic signed [15:0] drive_effort(logic [14:0] target,
                                                        logic signed [15:0] z);
        longint p;
        p = 2 * longint'(kp) * (longint'(target) - longint'(z));
        p = p >>> 8;
        if (p > 32767) return 16'sh7FFF;
        if (p < -32768) return 16'sh8000;
        return 16'(p);
    endfunction

    function automatic step_result_t steer_step(logic kind, logic signed [15:0] z,
                                                logic [31:0] t);
        step_result_t r;
        int target;
        int d;
        int step_dist;
        int lim;
        if (kind == 1'b0) begin
            if (!dive_done) begin
                target = int'(wp_tab[leg]);
                d = target - int'(z);
                step_dist = (d < 0) ? -d : d;
                if (step_dist > 65535) step_dist = 65535;
                held_dist = 16'(step_dist);
                if (step_dist < int'(margin) || dwell_on) begin
                    // a zero start reads as not started, so it latches again
                    if (dwell_t0 == 32'd0) dwell_t0 = t;
                    if (longint'(t) < longint'(dwell_t0) + longint'(hold_len)) begin
                        dwell_on = 1'b1;
                    end else begin
                        dwell_on = 1'b0;
                        dwell_t0 = 32'd0;
                        leg = leg + 2'd1;
                        lim = (wp_count == 3'd0) ? 1 :
                              (int'(wp_count) > MAX_POINTS) ? MAX_POINTS : int'(wp_count);
                        if (leg == 2'd0 || int'(leg) >= lim) begin
                            dive_done = 1'b1;
                            held_eff = '0;
                            leg = 2'd0;
                        end
                    end
                end
                if (!dive_done) held_eff = drive_effort(wp_tab[leg], z);
            end
            r.desired = wp_tab[leg];
        end else begin
            r.desired = '0;
            if (int'(z) < int'(margin) || dwell_on) begin
                surf_done = 1'b1;
                held_eff = '0;
            end else begin
                held_eff = -16'sd80;
            end
        end
        r.pad      = '0;
        r.effort   = held_eff;
        r.distance = held_dist;
        r.index    = leg;
        r.dwelling = dwell_on;
        r.reached  = dive_done;
        r.surfaced = surf_done;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        step_result_t got;
        step_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) wp_tab[i] = '0;
            wp_count  = 3'd1;
            hold_len  = '0;
            kp        = 16'd256;
            margin    = 12'd100;
            leg       = '0;
            dwell_on  = 1'b0;
            dwell_t0  = '0;
            dive_done = 1'b0;
            surf_done = 1'b0;
            held_eff  = '0;
            held_dist = '0;
            expected_steps.delete();
            pending    = 0;
            fail_count = 0;
        end else begin
            // compare before queuing so a same-edge step cannot match itself
            if (m_tvalid && m_tready) begin
                got = step_result_t'(m_tdata);
                if (expected_steps.size() == 0) begin
                    $display("%0t: result with no step pending, expected none got %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_steps.pop_front();
                    pending--;
                    check_field("effort", $signed(want.effort), $signed(got.effort));
                    check_field("desired_depth", want.desired, got.desired);
                    check_field("distance", want.distance, got.distance);
                    check_field("waypoint_index", want.index, got.index);
                    check_field("dwelling", want.dwelling, got.dwelling);
                    check_field("reached_depth", want.reached, got.reached);
                    check_field("surfaced", want.surfaced, got.surfaced);
                    check_field("zero fill", want.pad, got.pad);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WAYPOINT_A:     wp_tab[0] = cfg_data[14:0];
                    REG_WAYPOINT_B:     wp_tab[1] = cfg_data[14:0];
                    REG_WAYPOINT_C:     wp_tab[2] = cfg_data[14:0];
                    REG_WAYPOINT_D:     wp_tab[3] = cfg_data[14:0];
                    REG_WAYPOINT_COUNT: wp_count  = cfg_data[2:0];
                    REG_DWELL_TIME:     hold_len  = cfg_data;
                    REG_GAIN:           kp        = cfg_data;
                    REG_ARRIVAL_MARGIN: margin    = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_steps.push_back(steer_step(s_tuser, s_tdata[15:0], s_tdata[47:16]));
                pending++;
            end
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    import dwc_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no transaction on any channel
    localparam int LONG_HOLD   = 300;   // receiver back-pressure stretch

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic                   s_tuser   = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int fail_count;
    int pending_steps;

    // stimulus-side copy of the programmed registers, used only to aim steps
    logic [14:0] wp_set [4];
    logic [11:0] margin_set;
    logic [15:0] dwell_set;
    logic [31:0] now_ts;
    int          burst_left = 0;

    // receiver pattern state
    logic     hold_req     = 1'b0;
    bit       hold_done    = 1'b0;
    int       hold_left    = 0;
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    logic [2:0] rx_tick    = '0;

    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    depth_waypoint_controller_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predicts every accepted step and compares the result transactions
    waypoint_step_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending_steps)
    );

    // receiver: one long hold on request, otherwise a changing stall pattern
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 3'd1;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(16, 96);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (rx_tick < 3'd5);
            endcase
        end
    end

    // watchdog: any stretch without a transaction on any channel ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // one step transaction; the sender may idle between bursts of random length
    task automatic send_step(logic kind, logic signed [15:0] depth, logic [31:0] ts);
        int gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {ts, depth};
        do @(posedge aclk); while (!s_tready);
    endtask

    // register write; valid stays up so back-to-back writes need no gap
    task automatic write_reg(cfg_reg_t r, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (r)
            REG_WAYPOINT_A:     wp_set[0]  = v[14:0];
            REG_WAYPOINT_B:     wp_set[1]  = v[14:0];
            REG_WAYPOINT_C:     wp_set[2]  = v[14:0];
            REG_WAYPOINT_D:     wp_set[3]  = v[14:0];
            REG_DWELL_TIME:     dwell_set  = v;
            REG_ARRIVAL_MARGIN: margin_set = v[11:0];
            default: ;
        endcase
    endtask

    // stop offering and wait until every step has its result back
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge aclk); while (pending_steps != 0);
    endtask

    // depth at least the margin away from the waypoint
    function automatic logic signed [15:0] far_depth(int idx);
        int wp;
        int m;
        wp = int'(wp_set[idx]);
        m  = int'(margin_set);
        if (wp >= 16384) return 16'(-32768 + int'($urandom_range(wp - m + 32768)));
        return 16'(wp + m + int'($urandom_range(32767 - wp - m)));
    endfunction

    // depth strictly inside the margin, margin must be nonzero
    function automatic logic signed [15:0] near_depth(int idx);
        int d;
        d = int'(wp_set[idx]) + int'($urandom_range(2 * (int'(margin_set) - 1)))
            - (int'(margin_set) - 1);
        if (d > 32767) d = 32767;
        return 16'(d);
    endfunction

    task automatic noise_steps(int n);
        repeat (n) send_step($urandom_range(0, 3) == 0, 16'($urandom), $urandom);
    endtask

    // approach one waypoint, arrive, and sit out the dwell until it advances
    task automatic visit_waypoint(int idx);
        logic [31:0] start;
        bit          dwelling;
        bit          arrived;
        int          step_max;
        start    = '0;
        dwelling = 1'b0;
        arrived  = 1'b0;
        step_max = int'(dwell_set) / 32 + 1;
        // far away: steps that cannot arrive, some of them surface steps
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 5) == 0) send_step(1'b1, 16'($urandom), $urandom);
            else send_step(1'b0, far_depth(idx), $urandom);
        end
        while (!arrived) begin
            if (dwelling && $urandom_range(0, 7) == 0) begin
                // surface step while dwelling counts as surfaced
                send_step(1'b1, 16'($urandom), $urandom);
            end else begin
                // once dwelling, the depth no longer matters
                send_step(1'b0, (dwelling && $urandom_range(0, 2) == 0) ?
                          16'($urandom) : near_depth(idx), now_ts);
                if (start == 32'd0) start = now_ts;
                if (longint'(now_ts) < longint'(start) + longint'(dwell_set)) dwelling = 1'b1;
                else arrived = 1'b1;
                now_ts = now_ts + $urandom_range(1, step_max);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // registers start at their reset values
        wp_set     = '{default: '0};
        margin_set = 12'd100;
        dwell_set  = '0;

        // directed steps at reset settings: waypoint 0 at depth 0, margin 100
        send_step(1'b0, 16'sh8000, 32'd0);           // deepest error, saturates high
        send_step(1'b0, 16'sh7FFF, 32'hFFFF_FFFF);   // saturates low
        send_step(1'b0, 16'sd100, 32'd1);            // exactly at margin, not arrived
        send_step(1'b0, -16'sd100, 32'd2);
        send_step(1'b1, 16'sh7FFF, 32'd3);           // surface, push up
        send_step(1'b1, 16'sd100, 32'd4);            // surface at margin, still pushing
        send_step(1'b0, 16'sd777, 32'd5);
        send_step(1'b1, 16'sd99, 32'd6);             // below margin, surfaced
        send_step(1'b1, 16'sh8000, 32'd7);
        send_step(1'b1, 16'sd5000, 32'd8);           // surfaced stays, push up again
        send_step(1'b0, -16'sd5000, 32'd9);

        // largest gain and deepest waypoint, margin zero so nothing arrives
        drain();
        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_ARRIVAL_MARGIN, 16'd0);
        write_reg(REG_WAYPOINT_A, 16'h7FFF);
        send_step(1'b0, 16'sh8000, 32'd10);
        send_step(1'b0, 16'sh7FFF, 32'd11);          // zero error
        send_step(1'b1, 16'sd0, 32'd12);             // zero is not below a zero margin
        send_step(1'b1, -16'sd1, 32'd13);

        // smallest nonzero gain: negative products round toward minus infinity
        drain();
        write_reg(REG_WAYPOINT_A, 16'd0);
        write_reg(REG_GAIN, 16'd1);
        send_step(1'b0, 16'sd1, 32'd14);
        send_step(1'b0, -16'sd1, 32'd15);
        send_step(1'b0, 16'sh7FFF, 32'd16);
        drain();
        write_reg(REG_GAIN, 16'd0);
        send_step(1'b0, -16'sd12345, 32'd17);

        // random steps over several gains, still without arrival;
        // the first phase also holds the receiver off so the block backs up
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            if (ph == 0) hold_req <= 1'b1;
            write_reg(REG_GAIN, (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'd0 : 16'($urandom));
            write_reg(REG_ARRIVAL_MARGIN, 16'd0);
            write_reg(REG_WAYPOINT_A, 16'($urandom));
            write_reg(REG_WAYPOINT_B, 16'($urandom));
            write_reg(REG_WAYPOINT_C, 16'($urandom));
            write_reg(REG_WAYPOINT_D, 16'($urandom));
            write_reg(REG_WAYPOINT_COUNT, 16'($urandom));
            write_reg(REG_DWELL_TIME, 16'($urandom));
            noise_steps(25);
        end

        // the one dive tour: count above the maximum acts as four waypoints
        drain();
        write_reg(REG_WAYPOINT_A, 16'($urandom));
        write_reg(REG_WAYPOINT_B, 16'($urandom));
        write_reg(REG_WAYPOINT_C, 16'($urandom));
        write_reg(REG_WAYPOINT_D, 16'($urandom));
        write_reg(REG_WAYPOINT_COUNT, 16'd5);
        write_reg(REG_GAIN, 16'($urandom));
        write_reg(REG_ARRIVAL_MARGIN, 16'($urandom_range(1, 4095)));
        write_reg(REG_DWELL_TIME, 16'($urandom_range(1, 300)));
        now_ts = 32'd0;                              // arrival at time zero latches again
        visit_waypoint(0);

        drain();
        write_reg(REG_DWELL_TIME, 16'hFFFF);         // longest dwell, widest margin
        write_reg(REG_ARRIVAL_MARGIN, 16'd4095);
        visit_waypoint(1);

        drain();
        write_reg(REG_DWELL_TIME, 16'($urandom_range(0, 500)));
        write_reg(REG_ARRIVAL_MARGIN, 16'd1);        // only the exact depth arrives
        visit_waypoint(2);

        // count lowered to the current index: the next advance ends the dive
        drain();
        write_reg(REG_WAYPOINT_COUNT, 16'd3);
        write_reg(REG_DWELL_TIME, 16'd0);
        write_reg(REG_ARRIVAL_MARGIN, 16'($urandom_range(1, 4095)));
        now_ts = 32'hFFFF_FFF0;
        visit_waypoint(3);

        // after the dive: held effort on dive steps, surface compare near the margin
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            write_reg(REG_ARRIVAL_MARGIN, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd4095 :
                      16'($urandom));
            write_reg(REG_WAYPOINT_A, 16'($urandom));
            write_reg(REG_GAIN, 16'($urandom));
            write_reg(REG_DWELL_TIME, 16'($urandom));
            repeat (50) begin
                send_step($urandom_range(0, 1),
                          ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                          16'(int'(margin_set) + int'($urandom_range(6)) - 3),
                          $urandom);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending_steps == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/dwc_pkg.sv
rtl/dwc_cfg_regs.sv
rtl/dwc_effort.sv
rtl/dwc_core.sv
rtl/depth_waypoint_controller_top.sv
rtl/dwc_checker.sv
dv/waypoint_step_checker.sv
dv/testbench.sv
